FILE: rtl/gpbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpbs_pkg
// Shared types, constants and helper functions of the prefiltered scaler.
// ----------------------------------------------------------------------------
package gpbs_pkg;

   localparam int DEF_MAX_SRC_WIDTH  = 352;
   localparam int DEF_MAX_SRC_HEIGHT = 288;
   localparam int DEF_FRAC_BITS      = 8;

   localparam int COORD_W    = 10;   // pixel row or column
   localparam int SIZE_W     = 11;   // frame size, up to 1024
   localparam int FRAC_MAX_W = 12;   // widest fraction the queue carries
   localparam int MAX_DST    = 1024;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int ACC_W       = 16;  // 3x3 weighted sum of one channel

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_EN  = 3'd4;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Tap offset codes
   localparam logic [1:0] TAP_MINUS  = 2'd0;
   localparam logic [1:0] TAP_CENTRE = 2'd1;
   localparam logic [1:0] TAP_PLUS   = 2'd2;

   // Gaussian weights, Q8
   localparam logic [5:0] WT_CORNER = 6'd19;
   localparam logic [5:0] WT_EDGE   = 6'd32;
   localparam logic [5:0] WT_CENTRE = 6'd52;

   typedef struct packed {
      logic       op;
      logic [9:0] pix_row;
      logic [9:0] pix_col;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       is_read_reply;
      logic       bad_position;
   } rsp_type;

   // Effective (saturated) configuration seen by both halves
   typedef struct packed {
      logic [SIZE_W-1:0] src_w;
      logic [SIZE_W-1:0] src_h;
      logic [SIZE_W-1:0] dst_w;
      logic [SIZE_W-1:0] dst_h;
      logic              filt;
   } cfg_type;

   // One classified item as it travels from the front to the back
   typedef struct packed {
      logic                  op;
      logic                  bad;
      logic [COORD_W-1:0]    y0;
      logic [COORD_W-1:0]    x0;
      logic [COORD_W-1:0]    y1;
      logic [COORD_W-1:0]    x1;
      logic [FRAC_MAX_W-1:0] a_frac;
      logic [FRAC_MAX_W-1:0] b_frac;
      logic [23:0]           rgb;
   } item_type;

   // Tap position: reflect about the centre, then clamp to the frame.
   function automatic logic [COORD_W-1:0] tap_coord(input logic [COORD_W-1:0] c,
                                                    input logic [1:0] d,
                                                    input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] cp1;
      logic [SIZE_W-1:0] cm1;
      logic [SIZE_W-1:0] last;
      logic [SIZE_W-1:0] p;
      cp1  = {1'b0, c} + SIZE_W'(1);
      cm1  = {1'b0, c} - SIZE_W'(1);
      last = size - SIZE_W'(1);
      p    = {1'b0, c};
      unique case (d)
         TAP_MINUS: begin
            if (c != '0)       p = cm1;
            else if (cp1 < size) p = cp1;
            else               p = last;
         end
         TAP_PLUS: begin
            if (cp1 < size)    p = cp1;
            else if (c != '0)  p = cm1;
            else               p = '0;
         end
         TAP_CENTRE: p = {1'b0, c};
         default:    p = {1'b0, c};
      endcase
      return p[COORD_W-1:0];
   endfunction

   function automatic logic [5:0] tap_weight(input logic [1:0] tr, input logic [1:0] tc);
      logic rc;
      logic cc;
      rc = (tr == TAP_CENTRE);
      cc = (tc == TAP_CENTRE);
      if (rc && cc)      return WT_CENTRE;
      else if (rc || cc) return WT_EDGE;
      else               return WT_CORNER;
   endfunction

endpackage

FILE: rtl/gaussian_prefiltered_bilinear_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_prefiltered_bilinear_scaler
// RGB frame store with a Gaussian-prefiltered bilinear resize read path.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                               Handshake
//  -------  ----------------------------------  -------------------------------
//  request  start, busy, req_payload            taken when start & !busy
//  result   rsp_valid, rsp_payload              one-cycle strobe, no stall
//  config   csr_valid, csr_ready, csr_index,    written when valid & ready
//           csr_data
//
// A write item, or any item with a bad position, passes through the front's
// push state, the queue and the back's done state to its result strobe. A
// read item is limited by the single read port of the frame memory: each of
// the four neighbours needs nine reads with the filter on (one with it off),
// each a read and an accumulate state, plus a setup and a blend state. The
// front half maps a read through its multiply state and its two serial
// dividers, and works on the next item meanwhile.
// Reset is synchronous and clears all control state; the frame memory is not
// cleared and must be written before it is read.
// Results cannot be stalled: the receiver must take every strobe.
//
module gaussian_prefiltered_bilinear_scaler import gpbs_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   // Configuration registers, at their architectural widths.
   logic [8:0]  src_width_ff, src_height_ff;
   logic [10:0] dst_width_ff, dst_height_ff;
   logic        filter_en_ff;
   cfg_type     cfg;

   logic        push, full, empty, pop;
   item_type    push_item, head;

   // The port never pushes back; writes are to arrive only while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd352;
         src_height_ff <= 9'd288;
         dst_width_ff  <= 11'd352;
         dst_height_ff <= 11'd288;
         filter_en_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SRC_WIDTH:  src_width_ff  <= csr_data[8:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_data[8:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_data;
            REG_DST_HEIGHT: dst_height_ff <= csr_data;
            REG_FILTER_EN:  filter_en_ff  <= csr_data[0];
            default: ; // unknown index: ignored
         endcase
      end
   end

   // Sizes are saturated into their legal ranges before anyone sees them.
   always_comb begin
      cfg.src_w = (src_width_ff == '0) ? SIZE_W'(1)
                : (SIZE_W'(src_width_ff) > SIZE_W'(MAX_SRC_WIDTH)) ? SIZE_W'(MAX_SRC_WIDTH)
                : SIZE_W'(src_width_ff);
      cfg.src_h = (src_height_ff == '0) ? SIZE_W'(1)
                : (SIZE_W'(src_height_ff) > SIZE_W'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT)
                : SIZE_W'(src_height_ff);
      cfg.dst_w = (dst_width_ff == '0) ? SIZE_W'(1)
                : (dst_width_ff > SIZE_W'(MAX_DST)) ? SIZE_W'(MAX_DST) : dst_width_ff;
      cfg.dst_h = (dst_height_ff == '0) ? SIZE_W'(1)
                : (dst_height_ff > SIZE_W'(MAX_DST)) ? SIZE_W'(MAX_DST) : dst_height_ff;
      cfg.filt  = filter_en_ff;
   end

   // The front classifies each item and, for reads, finds the source
   // position and fractions; the back does memory work and the arithmetic.
   gpbs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .start(start), .req(req_payload), .cfg(cfg),
      .busy(busy), .push(push), .push_item(push_item), .full(full)
   );

   gpbs_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .head(head), .empty(empty), .full(full)
   );

   gpbs_back #(
      .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .head(head), .empty(empty),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
   );

endmodule

FILE: rtl/gpbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpbs_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NUM_W);
         num_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

FILE: rtl/gpbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpbs_front
// Accepts items, checks positions and maps read positions to the source grid.
// ----------------------------------------------------------------------------
module gpbs_front import gpbs_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   input  cfg_type  cfg,
   output logic     busy,
   output logic     push,
   output item_type push_item,
   input  logic     full
);
   localparam int PROD_W = 21;
   localparam int NUM_W  = PROD_W + FRAC_BITS;

   typedef enum logic [4:0] {
      F_IDLE  = 5'b00001,
      F_MUL   = 5'b00010,
      F_START = 5'b00100,
      F_DIV   = 5'b01000,
      F_PUSH  = 5'b10000
   } fstate_type;

   fstate_type         state_ff, state_in;
   item_type           item_ff, item_in;
   logic [PROD_W-1:0]  prod_y_ff, prod_y_in, prod_x_ff, prod_x_in;
   logic               div_done_y, div_done_x;
   logic [NUM_W-1:0]   quo_y, quo_x;
   logic [COORD_W-1:0] y0, x0;
   logic [SIZE_W-1:0]  y0p1, x0p1;
   logic               bad;

   assign bad = (req.op == OP_WRITE)
              ? (({1'b0, req.pix_row} >= cfg.src_h) || ({1'b0, req.pix_col} >= cfg.src_w))
              : (({1'b0, req.pix_row} >= cfg.dst_h) || ({1'b0, req.pix_col} >= cfg.dst_w));

   assign y0   = quo_y[FRAC_BITS +: COORD_W];
   assign x0   = quo_x[FRAC_BITS +: COORD_W];
   assign y0p1 = {1'b0, y0} + SIZE_W'(1);
   assign x0p1 = {1'b0, x0} + SIZE_W'(1);

   gpbs_div #(.NUM_W(NUM_W), .DEN_W(SIZE_W)) u_div_y (
      .clock(clock), .reset(reset), .start(state_ff == F_START),
      .numer({prod_y_ff, {FRAC_BITS{1'b0}}}), .denom(cfg.dst_h),
      .done(div_done_y), .quotient(quo_y)
   );

   gpbs_div #(.NUM_W(NUM_W), .DEN_W(SIZE_W)) u_div_x (
      .clock(clock), .reset(reset), .start(state_ff == F_START),
      .numer({prod_x_ff, {FRAC_BITS{1'b0}}}), .denom(cfg.dst_w),
      .done(div_done_x), .quotient(quo_x)
   );

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      prod_y_in = prod_y_ff;
      prod_x_in = prod_x_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               item_in        = '0;
               item_in.op     = req.op;
               item_in.bad    = bad;
               item_in.y0     = req.pix_row;
               item_in.x0     = req.pix_col;
               item_in.rgb    = {req.in_red, req.in_green, req.in_blue};
               state_in = ((req.op == OP_WRITE) || bad) ? F_PUSH : F_MUL;
            end
         end
         F_MUL: begin
            prod_y_in = PROD_W'(cfg.src_h) * PROD_W'(item_ff.y0);
            prod_x_in = PROD_W'(cfg.src_w) * PROD_W'(item_ff.x0);
            state_in  = F_START;
         end
         F_START: state_in = F_DIV;
         F_DIV: begin
            if (div_done_y && div_done_x) begin
               item_in.y0     = y0;
               item_in.x0     = x0;
               item_in.y1     = (y0p1 < cfg.src_h) ? y0p1[COORD_W-1:0]
                                                   : COORD_W'(cfg.src_h - SIZE_W'(1));
               item_in.x1     = (x0p1 < cfg.src_w) ? x0p1[COORD_W-1:0]
                                                   : COORD_W'(cfg.src_w - SIZE_W'(1));
               item_in.b_frac = FRAC_MAX_W'(quo_y[FRAC_BITS-1:0]);
               item_in.a_frac = FRAC_MAX_W'(quo_x[FRAC_BITS-1:0]);
               state_in = F_PUSH;
            end
         end
         F_PUSH: if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff   <= item_in;
      prod_y_ff <= prod_y_in;
      prod_x_ff <= prod_x_in;
   end

   assign busy      = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !full;
   assign push_item = item_ff;

   // An accepted item always leaves the front busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("front did not go busy after accepting an item");

endmodule

FILE: rtl/gpbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpbs_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module gpbs_queue import gpbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     empty,
   output logic     full
);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

FILE: rtl/gpbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpbs_back
// Frame memory, optional 3x3 prefilter of each neighbour and bilinear blend.
// ----------------------------------------------------------------------------
module gpbs_back import gpbs_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
   parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type head,
   input  logic     empty,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_payload
);
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WAB_W = 2 * FRAC_BITS + 2;
   localparam int SUM_W = 2 * FRAC_BITS + 10;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_PREP  = 6'b000010,
      B_READ  = 6'b000100,
      B_ACCUM = 6'b001000,
      B_MIX   = 6'b010000,
      B_DONE  = 6'b100000
   } bstate_type;

   bstate_type         state_ff, state_in;
   item_type           cur_ff, cur_in;
   logic [1:0]         nb_ff, nb_in;
   logic [1:0]         tr_ff, tr_in, tc_ff, tc_in;
   logic [WAB_W-1:0]   wab_ff, wab_in;
   logic [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]   acc_in [3];
   logic [SUM_W-1:0]   sum_ff [3];
   logic [SUM_W-1:0]   sum_in [3];
   logic [23:0]        mem [DEPTH];
   logic [23:0]        rd_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               mem_we;
   logic [COORD_W-1:0] cen_r, cen_c, tap_r, tap_c;
   logic [FRAC_BITS:0] wa, wb;
   logic [FRAC_BITS-1:0] a_f, b_f;
   logic [5:0]         wt;
   logic               last_tap;

   assign a_f   = cur_ff.a_frac[FRAC_BITS-1:0];
   assign b_f   = cur_ff.b_frac[FRAC_BITS-1:0];
   assign wa    = nb_ff[0] ? {1'b0, a_f} : ONE - {1'b0, a_f};
   assign wb    = nb_ff[1] ? {1'b0, b_f} : ONE - {1'b0, b_f};
   assign cen_r = nb_ff[1] ? cur_ff.y1 : cur_ff.y0;
   assign cen_c = nb_ff[0] ? cur_ff.x1 : cur_ff.x0;
   assign tap_r = cfg.filt ? tap_coord(cen_r, tr_ff, cfg.src_h) : cen_r;
   assign tap_c = cfg.filt ? tap_coord(cen_c, tc_ff, cfg.src_w) : cen_c;
   assign wt    = tap_weight(tr_ff, tc_ff);
   assign last_tap = !cfg.filt || ((tr_ff == TAP_PLUS) && (tc_ff == TAP_PLUS));

   assign rd_addr = AW'(tap_r * MAX_SRC_WIDTH + tap_c);
   assign wr_addr = AW'(head.y0 * MAX_SRC_WIDTH + head.x0);
   assign pop     = (state_ff == B_IDLE) && !empty;
   assign mem_we  = pop && (head.op == OP_WRITE) && !head.bad;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= head.rgb;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      nb_in    = nb_ff;
      tr_in    = tr_ff;
      tc_in    = tc_ff;
      wab_in   = wab_ff;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = acc_ff[k];
         sum_in[k] = sum_ff[k];
      end
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               cur_in = head;
               nb_in  = '0;
               for (int k = 0; k < 3; k++) sum_in[k] = '0;
               state_in = ((head.op == OP_WRITE) || head.bad) ? B_DONE : B_PREP;
            end
         end
         B_PREP: begin
            wab_in = WAB_W'(wa) * WAB_W'(wb);
            tr_in  = cfg.filt ? TAP_MINUS : TAP_CENTRE;
            tc_in  = cfg.filt ? TAP_MINUS : TAP_CENTRE;
            for (int k = 0; k < 3; k++) acc_in[k] = '0;
            state_in = B_READ;
         end
         B_READ: state_in = B_ACCUM;
         B_ACCUM: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = cfg.filt
                  ? ACC_W'(acc_ff[k] + wt * rd_ff[8*(2-k) +: 8])
                  : {rd_ff[8*(2-k) +: 8], 8'b0};
            end
            if (last_tap) begin
               state_in = B_MIX;
            end else begin
               if (tc_ff == TAP_PLUS) begin
                  tc_in = TAP_MINUS;
                  tr_in = tr_ff + 2'd1;
               end else begin
                  tc_in = tc_ff + 2'd1;
               end
               state_in = B_READ;
            end
         end
         B_MIX: begin
            for (int k = 0; k < 3; k++)
               sum_in[k] = SUM_W'(sum_ff[k] + acc_ff[k][15:8] * wab_ff);
            nb_in    = nb_ff + 2'd1;
            state_in = (nb_ff == 2'd3) ? B_DONE : B_PREP;
         end
         B_DONE: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff <= cur_in;
      nb_ff  <= nb_in;
      tr_ff  <= tr_in;
      tc_ff  <= tc_in;
      wab_ff <= wab_in;
      for (int k = 0; k < 3; k++) begin
         acc_ff[k] <= acc_in[k];
         sum_ff[k] <= sum_in[k];
      end
   end

   logic show_color;
   assign show_color = (cur_ff.op == OP_READ) && !cur_ff.bad;

   assign rsp_valid                 = (state_ff == B_DONE);
   assign rsp_payload.out_red       = show_color ? sum_ff[0][2*FRAC_BITS +: 8] : 8'd0;
   assign rsp_payload.out_green     = show_color ? sum_ff[1][2*FRAC_BITS +: 8] : 8'd0;
   assign rsp_payload.out_blue      = show_color ? sum_ff[2][2*FRAC_BITS +: 8] : 8'd0;
   assign rsp_payload.is_read_reply = (cur_ff.op == OP_READ);
   assign rsp_payload.bad_position  = cur_ff.bad;

   // Results are strobes of exactly one cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule
